/* rtl/ssbi_pkg.sv */
// Shared types and codes for the sorted sample buffer with interpolation.
// Used by the controller, the datapath and the top level; no dependencies.
package ssbi_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_VAL_AT = 2'd1;
    localparam logic [1:0] FUNC_KEY_AT = 2'd2;

    localparam int DIV_STEPS = 64;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_FAIL,
        OP_RD_IDX,
        OP_RD_LAST,
        OP_STEP,
        OP_RES_DIRECT,
        OP_OPND,
        OP_MUL,
        OP_DIV_STEP,
        OP_RES_INTERP,
        OP_INS_OK,
        OP_SET_J,
        OP_RD_SHIFT,
        OP_WR_SHIFT,
        OP_WR_NEW,
        OP_RD_MIN,
        OP_CAP_MIN,
        OP_CAP_MAX,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       cnt_lt2;
        logic       full;
        logic       idx_at_cnt;
        logic       idx_zero;
        logic       key_lt;
        logic       key_eq;
        logic       val_lt;
        logic       val_eq;
        logic       below_prev;
        logic       shift_done;
        logic       div_last;
    } dp_stat_t;

endpackage

/* rtl/ssbi_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ssbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ssbi_dp.sv */
// Datapath: sample stores, scan registers, multiplier, divider, result registers.
// Depends on ssbi_pkg and ssbi_ram.
module ssbi_dp
    import ssbi_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [1:0]         func,
    input  logic [31:0]        key,
    input  logic signed [31:0] value,
    output logic               ok,
    output logic signed [31:0] out_value,
    output logic [31:0]        out_key,
    output logic [6:0]         fill_count,
    output logic [31:0]        min_key,
    output logic [31:0]        max_key
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]         func_reg;
    logic [31:0]        k_reg;
    logic signed [31:0] v_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      j_reg;
    logic [31:0]        k_prev_reg;
    logic signed [31:0] v_prev_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [31:0]        d_reg;
    logic [31:0]        base_reg;
    logic               neg_reg;
    logic [63:0]        dvd_reg;
    logic [31:0]        rem_reg;
    logic [5:0]         step_reg;
    logic               res_ok_reg;
    logic [31:0]        res_val_reg;
    logic [31:0]        res_key_reg;
    logic [31:0]        min_reg;
    logic [31:0]        max_reg;
    logic               ok_reg;
    logic [31:0]        out_value_reg;
    logic [31:0]        out_key_reg;
    logic [6:0]         fill_count_reg;
    logic [31:0]        min_key_reg;
    logic [31:0]        max_key_reg;

    logic               full;
    logic [CW-1:0]      cnt_m1;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               we;
    logic [31:0]        wkey;
    logic [31:0]        wval;
    logic [31:0]        rd_key;
    logic signed [31:0] rd_val;
    logic [32:0]        dv;
    logic [32:0]        dv_mag;
    logic [32:0]        rem_sh;
    logic [32:0]        rem_diff;

    assign full   = (count_reg == CW'(DEPTH));
    assign cnt_m1 = count_reg - CW'(1);

    always_comb
    begin
        unique case (cmd.op)
            OP_RD_IDX:   raddr = idx_reg[AW-1:0];
            OP_RD_LAST:  raddr = cnt_m1[AW-1:0];
            OP_CAP_MIN:  raddr = cnt_m1[AW-1:0];
            OP_RD_SHIFT: raddr = full ? j_reg[AW-1:0] : AW'(j_reg - CW'(1));
            default:     raddr = '0;
        endcase
    end

    always_comb
    begin
        we   = 1'b0;
        wkey = k_reg;
        wval = v_reg;
        unique case (cmd.op)
            OP_WR_SHIFT:
            begin
                we    = 1'b1;
                waddr = full ? AW'(j_reg - CW'(1)) : j_reg[AW-1:0];
                wkey  = rd_key;
                wval  = rd_val;
            end
            OP_WR_NEW:
            begin
                we    = 1'b1;
                waddr = full ? AW'(idx_reg - CW'(1)) : idx_reg[AW-1:0];
            end
            default:
            begin
                waddr = '0;
            end
        endcase
    end

    ssbi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wkey),
        .raddr (raddr),
        .rdata (rd_key)
    );

    ssbi_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wval),
        .raddr (raddr),
        .rdata (rd_val)
    );

    assign dv       = {rd_val[31], rd_val} - {v_prev_reg[31], v_prev_reg};
    assign dv_mag   = dv[32] ? (33'd0 - dv) : dv;
    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign rem_diff = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        stat.func       = func_reg;
        stat.cnt_lt2    = (count_reg < CW'(2));
        stat.full       = full;
        stat.idx_at_cnt = (idx_reg == count_reg);
        stat.idx_zero   = (idx_reg == '0);
        stat.key_lt     = (rd_key < k_reg);
        stat.key_eq     = (rd_key == k_reg);
        stat.val_lt     = (rd_val < v_reg);
        stat.val_eq     = (rd_val == v_reg);
        stat.below_prev = (v_reg < v_prev_reg);
        stat.shift_done = (j_reg == idx_reg);
        stat.div_last   = (step_reg == 6'(DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.op == OP_WR_NEW && !full)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                func_reg    <= func;
                k_reg       <= key;
                v_reg       <= value;
                idx_reg     <= '0;
                res_ok_reg  <= 1'b0;
                res_val_reg <= '0;
                res_key_reg <= '0;
            end
            OP_FAIL:
            begin
                res_ok_reg  <= 1'b0;
                res_val_reg <= '0;
                res_key_reg <= '0;
            end
            OP_STEP:
            begin
                k_prev_reg <= rd_key;
                v_prev_reg <= rd_val;
                idx_reg    <= idx_reg + CW'(1);
            end
            OP_RES_DIRECT:
            begin
                res_ok_reg <= 1'b1;
                if (func_reg == FUNC_VAL_AT)
                begin
                    res_val_reg <= rd_val;
                end
                else
                begin
                    res_key_reg <= rd_key;
                end
            end
            OP_OPND:
            begin
                if (func_reg == FUNC_VAL_AT)
                begin
                    a_reg    <= k_reg - k_prev_reg;
                    b_reg    <= dv_mag[31:0];
                    d_reg    <= rd_key - k_prev_reg;
                    neg_reg  <= dv[32];
                    base_reg <= v_prev_reg;
                end
                else
                begin
                    a_reg    <= v_reg - v_prev_reg;
                    b_reg    <= rd_key - k_prev_reg;
                    d_reg    <= dv[31:0];
                    neg_reg  <= 1'b0;
                    base_reg <= k_prev_reg;
                end
            end
            OP_MUL:
            begin
                dvd_reg  <= 64'(a_reg) * 64'(b_reg);
                rem_reg  <= '0;
                step_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                step_reg <= step_reg + 6'd1;
                if (!rem_diff[32])
                begin
                    rem_reg <= rem_diff[31:0];
                    dvd_reg <= {dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                end
            end
            OP_RES_INTERP:
            begin
                res_ok_reg <= 1'b1;
                if (func_reg == FUNC_VAL_AT)
                begin
                    res_val_reg <= neg_reg ? base_reg - dvd_reg[31:0]
                                           : base_reg + dvd_reg[31:0];
                end
                else
                begin
                    res_key_reg <= base_reg + dvd_reg[31:0];
                end
            end
            OP_INS_OK:
            begin
                res_ok_reg <= 1'b1;
            end
            OP_SET_J:
            begin
                j_reg <= full ? CW'(1) : count_reg;
            end
            OP_WR_SHIFT:
            begin
                j_reg <= full ? j_reg + CW'(1) : j_reg - CW'(1);
            end
            OP_WR_NEW:
            begin
                res_ok_reg <= 1'b1;
            end
            OP_CAP_MIN:
            begin
                min_reg <= (count_reg == '0) ? 32'd0 : rd_key;
            end
            OP_CAP_MAX:
            begin
                max_reg <= (count_reg == '0) ? 32'd0 : rd_key;
            end
            OP_PUBLISH:
            begin
                ok_reg         <= res_ok_reg;
                out_value_reg  <= res_val_reg;
                out_key_reg    <= res_key_reg;
                fill_count_reg <= 7'(count_reg);
                min_key_reg    <= min_reg;
                max_key_reg    <= max_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign ok         = ok_reg;
    assign out_value  = out_value_reg;
    assign out_key    = out_key_reg;
    assign fill_count = fill_count_reg;
    assign min_key    = min_key_reg;
    assign max_key    = max_key_reg;

endmodule

/* rtl/ssbi_ctrl.sv */
// Controller state machine: sequences scan, shift, divide and result steps.
// Depends on ssbi_pkg.
module ssbi_ctrl
    import ssbi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_LAST_W,
        S_SCAN,
        S_SCAN_W,
        S_INS_POS,
        S_SH_CHK,
        S_SH_WR,
        S_MUL,
        S_DIV,
        S_RESULT,
        S_MM0,
        S_MM1,
        S_MM2,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   publish;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign publish   = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.func == FUNC_INSERT)
                begin
                    state_next = S_SCAN;
                end
                else if ((stat.func != FUNC_VAL_AT && stat.func != FUNC_KEY_AT)
                         || stat.cnt_lt2)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = S_MM0;
                end
                else if (stat.func == FUNC_VAL_AT)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.op     = OP_RD_LAST;
                    state_next = S_LAST_W;
                end
            end
            S_LAST_W:
            begin
                // Query above the last stored value fails.
                if (stat.val_lt)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = S_MM0;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.idx_at_cnt)
                begin
                    if (stat.func == FUNC_INSERT)
                    begin
                        state_next = S_INS_POS;
                    end
                    else
                    begin
                        cmd.op     = OP_FAIL;
                        state_next = S_MM0;
                    end
                end
                else
                begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_SCAN_W;
                end
            end
            S_SCAN_W:
            begin
                if (stat.func == FUNC_INSERT)
                begin
                    priority if (stat.key_lt)
                    begin
                        cmd.op     = OP_STEP;
                        state_next = S_SCAN;
                    end
                    else if (stat.key_eq)
                    begin
                        cmd.op     = OP_FAIL;
                        state_next = S_MM0;
                    end
                    else
                    begin
                        state_next = S_INS_POS;
                    end
                end
                else if (stat.func == FUNC_VAL_AT)
                begin
                    priority if (stat.idx_zero)
                    begin
                        if (!stat.key_lt && !stat.key_eq)
                        begin
                            cmd.op     = OP_FAIL;
                            state_next = S_MM0;
                        end
                        else
                        begin
                            cmd.op     = OP_STEP;
                            state_next = S_SCAN;
                        end
                    end
                    else if (stat.key_eq)
                    begin
                        cmd.op     = OP_RES_DIRECT;
                        state_next = S_MM0;
                    end
                    else if (stat.key_lt)
                    begin
                        cmd.op     = OP_STEP;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.op     = OP_OPND;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    priority if (stat.idx_zero)
                    begin
                        if (!stat.val_lt && !stat.val_eq)
                        begin
                            cmd.op     = OP_FAIL;
                            state_next = S_MM0;
                        end
                        else
                        begin
                            cmd.op     = OP_STEP;
                            state_next = S_SCAN;
                        end
                    end
                    else if (stat.val_eq)
                    begin
                        cmd.op     = OP_RES_DIRECT;
                        state_next = S_MM0;
                    end
                    else if (stat.val_lt)
                    begin
                        cmd.op     = OP_STEP;
                        state_next = S_SCAN;
                    end
                    else if (stat.below_prev)
                    begin
                        cmd.op     = OP_FAIL;
                        state_next = S_MM0;
                    end
                    else
                    begin
                        cmd.op     = OP_OPND;
                        state_next = S_MUL;
                    end
                end
            end
            S_INS_POS:
            begin
                // A key below every stored key is dropped when the store is full.
                if (stat.full && stat.idx_zero)
                begin
                    cmd.op     = OP_INS_OK;
                    state_next = S_MM0;
                end
                else
                begin
                    cmd.op     = OP_SET_J;
                    state_next = S_SH_CHK;
                end
            end
            S_SH_CHK:
            begin
                if (stat.shift_done)
                begin
                    cmd.op     = OP_WR_NEW;
                    state_next = S_MM0;
                end
                else
                begin
                    cmd.op     = OP_RD_SHIFT;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.op     = OP_WR_SHIFT;
                state_next = S_SH_CHK;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                cmd.op     = OP_RES_INTERP;
                state_next = S_MM0;
            end
            S_MM0:
            begin
                cmd.op     = OP_RD_MIN;
                state_next = S_MM1;
            end
            S_MM1:
            begin
                cmd.op     = OP_CAP_MIN;
                state_next = S_MM2;
            end
            S_MM2:
            begin
                cmd.op     = OP_CAP_MAX;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (publish)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/sorted_sample_buffer_interp_top.sv */
// Sorted sample buffer with linear interpolation, one request at a time.
// An insert scans the stored keys up to its position, then shifts entries to open its
// slot; a lookup scans the entries and, when it interpolates, runs a 64-step restoring
// divider. A new request is taken only after the previous result has been registered.
// Reset (rst_n, asynchronous) empties the buffer; the sample RAMs need no clearing.
module sorted_sample_buffer_interp_top
    import ssbi_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [31:0]        key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic signed [31:0] out_value,
    output logic [31:0]        out_key,
    output logic [6:0]         fill_count,
    output logic [31:0]        min_key,
    output logic [31:0]        max_key
);

    // The controller issues one datapath command per cycle and branches on
    // the compare flags that the datapath returns.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    ssbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds both sample RAMs, the scan and divider registers,
    // and the output register that keeps a result while the consumer stalls.
    ssbi_dp #(.DEPTH(DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (func),
        .key        (key),
        .value      (value),
        .ok         (ok),
        .out_value  (out_value),
        .out_key    (out_key),
        .fill_count (fill_count),
        .min_key    (min_key),
        .max_key    (max_key)
    );

endmodule
